### src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on the rising clock edge outside reset
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CHK_SAME(label, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/sitda_pkg.sv
// shared types and constants of the signed integer to decimal text block
// no dependencies
package sitda_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam int NUM_DIGITS = 10;
	localparam int IDX_W      = $clog2(NUM_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_REM,
		ST_SIGN,
		ST_DIGIT,
		ST_TAB
	} state_t;

	typedef enum logic [1:0] {
		SEL_MINUS,
		SEL_DIGIT,
		SEL_TAB
	} out_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul;
		logic     rem;
		logic     load_out;
		out_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic q_zero;
		logic last_digit;
		logic out_free;
	} status_t;

endpackage

### src/sitda_ctrl.sv
// controller state machine: sequences digit extraction and byte output
// depends on sitda_pkg
module sitda_ctrl
	import sitda_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_REM;
			end
			ST_REM: begin
				if (!status.q_zero) state_d = ST_MUL;
				else if (status.neg) state_d = ST_SIGN;
				else state_d = ST_DIGIT;
			end
			ST_SIGN: begin
				if (status.out_free) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (status.out_free && status.last_digit) state_d = ST_TAB;
			end
			ST_TAB: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = SEL_TAB;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
			end
			ST_SIGN: begin
				cmd.load_out = status.out_free;
				cmd.sel      = SEL_MINUS;
			end
			ST_DIGIT: begin
				cmd.load_out = status.out_free;
				cmd.sel      = SEL_DIGIT;
			end
			ST_TAB: begin
				cmd.load_out = status.out_free;
				cmd.sel      = SEL_TAB;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### src/sitda_dp.sv
// datapath: magnitude, divide-by-ten step, digit store and output register
// depends on sitda_pkg
module sitda_dp
	import sitda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [7:0]  character,
	output logic               last
);

	logic [31:0]      mag_q;
	logic             neg_q;
	logic [63:0]      prod_q;
	logic [3:0]       digits_q [NUM_DIGITS];
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic [31:0]      quot;
	logic [31:0]      quot_x10;
	logic [31:0]      rem_full;
	logic [IDX_W-1:0] idx_m1;
	logic [7:0]       char_d;

	// quotient from the registered reciprocal product, remainder by shift-add
	assign quot     = 32'(prod_q[63:RECIP_SHIFT]);
	assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
	assign rem_full = mag_q - quot_x10;
	assign idx_m1   = idx_q - IDX_W'(1);

	always_comb begin
		case (cmd.sel)
			SEL_MINUS: char_d = CH_MINUS;
			SEL_DIGIT: char_d = CH_ZERO + {4'b0000, digits_q[idx_m1]};
			SEL_TAB:   char_d = CH_TAB;
			default:   char_d = CH_TAB;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (32'd0 - 32'(value)) : 32'(value);
		end else if (cmd.rem) begin
			mag_q <= quot;
		end
		if (cmd.mul) begin
			prod_q <= 64'(mag_q) * 64'(RECIP_TEN);
		end
		if (cmd.rem) begin
			digits_q[idx_q] <= rem_full[3:0];
		end
		if (cmd.load_out) begin
			char_q <= char_d;
			last_q <= (cmd.sel == SEL_TAB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				idx_q <= '0;
			end else if (cmd.rem) begin
				idx_q <= idx_q + IDX_W'(1);
			end else if (cmd.load_out && cmd.sel == SEL_DIGIT) begin
				idx_q <= idx_m1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.neg        = neg_q;
	assign status.q_zero     = (quot == 32'd0);
	assign status.last_digit = (idx_q == IDX_W'(1));
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

### src/signed_int_to_decimal_ascii_core.sv
// top level: signed 32-bit integer to decimal ascii text with tab terminator
// depends on sitda_pkg, sitda_ctrl, sitda_dp and assert_macros.svh
//
// channel  dir  handshake            payload
// input    in   in_valid/in_stall    value (32-bit signed)
// output   out  out_valid/out_stall  character (8), last (1)
//
// one word in gives 2 to 12 words out: optional '-', digits msb first, tab with last
// steps per word: accept, then a reciprocal multiply and a remainder step per decimal digit,
// then each output byte loaded in turn, waiting while the output stalls
// the divide-by-ten loop and the single output register set the rate
// arst_n clears the state machine, digit index and output valid; nothing else is kept
// a stalled output holds the byte; the next word is taken while the tab still waits
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [7:0]  character,
	output logic               last
);

	cmd_t    cmd;
	status_t status;

	// controller: decides when to load, divide, and push a byte
	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: magnitude, digit store and registered output byte
	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// an accepted word keeps the input side busy in the next cycle
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall,
		"input accepted again right after accept")

	// the terminator byte and the last flag go together
	`CHK_SAME(a_last_is_tab, clk, arst_n, out_valid && last, character == CH_TAB,
		"last byte is not a tab")
	`CHK_SAME(a_tab_is_last, clk, arst_n, out_valid && !last, character != CH_TAB,
		"tab byte without last")

	// a byte is never loaded while the controller still divides
	`CHK_SAME(a_no_load_in_divide, clk, arst_n, cmd.mul || cmd.rem, !cmd.load_out,
		"output loaded during digit extraction")

endmodule

### verif/signed_int_to_decimal_ascii_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for signed_int_to_decimal_ascii_core: random and corner values in,
// decimal text bytes out, checked against a predicted byte queue
// depends on sitda_pkg and the rtl of the block

module signed_int_to_decimal_ascii_core_tb
	import sitda_pkg::*;
();

	localparam int PHASE_WORDS      = 137;
	localparam int CORNER_WORDS     = 16;
	localparam int LONG_HOLD_CYCLES = 400;
	// longer than the worst case per word in the rtl, so this covers any late byte
	localparam int DRAIN_CYCLES     = 40;
	// start the long receiver hold a little way into the phase without idling
	localparam int HOLD_AT          = CORNER_WORDS + 2 * PHASE_WORDS + 20;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_byte_t;

	// expected text bytes, oldest first
	class decimal_text_scoreboard;
		text_byte_t expected_bytes[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// append the text of one accepted word: sign, digits msb first, tab
		function void note_value(input logic signed [31:0] v);
			logic [31:0] magnitude;
			logic [7:0]  digit_chars[$];
			// unsigned magnitude, so the most negative value stays 2147483648
			magnitude = v[31] ? (32'd0 - v) : v;
			if (v[31]) begin
				expected_bytes.push_back('{character: CH_MINUS, last: 1'b0});
			end
			// a zero still yields one digit
			do begin
				digit_chars.push_front(CH_ZERO + 8'(magnitude % 32'd10));
				magnitude = magnitude / 32'd10;
			end while (magnitude != 0);
			foreach (digit_chars[i]) begin
				expected_bytes.push_back('{character: digit_chars[i], last: 1'b0});
			end
			expected_bytes.push_back('{character: CH_TAB, last: 1'b1});
		endfunction

		function void check_byte(input logic [7:0] ch, input logic lst);
			text_byte_t want;
			if (expected_bytes.size() == 0) begin
				$error("unexpected word: character %h last %b", ch, lst);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (ch !== want.character) begin
				$error("character: expected %h, actual %h", want.character, ch);
				errors++;
			end
			if (lst !== want.last) begin
				$error("last: expected %b, actual %b", want.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [7:0]  character;
	logic               last;

	decimal_text_scoreboard sb;
	int sender_idle_pct = 0;
	int recv_idle_pct   = 0;
	int words_sent      = 0;
	int hold_left       = 0;
	bit hold_done       = 1'b0;

	logic signed [31:0] corner_values [CORNER_WORDS] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
		32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sd1000000000,
		32'sd999999999, -32'sd999999999, 32'sd123456789, -32'sd5
	};

	signed_int_to_decimal_ascii_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: check every accepted byte, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_byte(character, last);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && words_sent >= HOLD_AT) begin
				// one long hold so the block backs up into its input
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic logic [31:0] power_of_ten(input int n);
		logic [31:0] p;
		p = 32'd1;
		repeat (n) p = p * 32'd10;
		return p;
	endfunction

	// mix of raw 32-bit patterns, values of a random digit count, and powers of ten +-1
	function automatic logic signed [31:0] random_value();
		int unsigned pick;
		int          digits;
		logic [31:0] r;
		pick = $urandom_range(99);
		if (pick < 35) begin
			r = $urandom;
		end else begin
			if (pick < 80) begin
				digits = $urandom_range(10, 1);
				r = $urandom_range(digits == 10 ? 32'h8000_0000 : power_of_ten(digits) - 1,
					digits == 1 ? 32'd0 : power_of_ten(digits - 1));
			end else begin
				r = power_of_ten($urandom_range(9)) - 32'd1 + $urandom_range(2);
			end
			if ($urandom_range(1)) begin
				r = 32'd0 - r;
			end
		end
		return r;
	endfunction

	// offer one word, with random idle cycles first, and hold it until accepted
	task automatic send_word(input logic signed [31:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		sb.note_value(v);
		words_sent++;
	endtask

	task automatic run_phase(input int n, input int snd_pct, input int rcv_pct);
		sender_idle_pct = snd_pct;
		recv_idle_pct   = rcv_pct;
		repeat (n) send_word(random_value());
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 14;
		recv_idle_pct   = 55;
		foreach (corner_values[i]) send_word(corner_values[i]);

		run_phase(PHASE_WORDS, 14, 55);
		run_phase(PHASE_WORDS, 55, 14);
		run_phase(PHASE_WORDS, 0, 0);
		@(posedge clk);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule
